// ----- rtl/tcw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, action and character codes, and the command and status
// types that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int ACTION_W  = 2;
	localparam int CHAR_W    = 8;
	localparam int ATTR_W    = 8;
	localparam int INDEX_W   = 11;
	localparam int DATA_W    = 16;
	localparam int COLPORT_W = 7;
	localparam int ROWPORT_W = 5;

	localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
	localparam logic [ATTR_W-1:0] PAD_ATTR   = 8'h0f;

	localparam int TAB_SPACES = 4;
	localparam int TAB_W      = 3;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_LATCH,
		DP_PUT,
		DP_SCROLL,
		DP_ZERO,
		DP_RESULT
	} dp_cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic                put_bottom;
		logic                put_more;
		logic                more_q;
		logic                scroll_last;
		logic                zero_last;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/tcw_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/tcw_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences each request through put, scroll, clear and read steps and
// holds the result valid flag.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire tcw_pkg::dp_status_t status,
	output tcw_pkg::dp_cmd_t        cmd
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DISPATCH,
		S_PUT,
		S_SCROLL,
		S_CLEAR,
		S_READ,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = tcw_pkg::DP_NONE;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				cmd = tcw_pkg::DP_ZERO;
				if (status.zero_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd     = tcw_pkg::DP_LATCH;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (status.act)
					tcw_pkg::ACT_PUT:   state_d = S_PUT;
					tcw_pkg::ACT_READ:  state_d = S_READ;
					tcw_pkg::ACT_CLEAR: state_d = S_CLEAR;
					default:            state_d = S_FINISH;
				endcase
			end
			S_PUT: begin
				cmd = tcw_pkg::DP_PUT;
				if (status.put_bottom) begin
					state_d = S_SCROLL;
				end else if (status.put_more) begin
					state_d = S_PUT;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCROLL: begin
				cmd = tcw_pkg::DP_SCROLL;
				if (status.scroll_last) begin
					state_d = status.more_q ? S_PUT : S_FINISH;
				end
			end
			S_CLEAR: begin
				cmd = tcw_pkg::DP_ZERO;
				if (status.zero_last) begin
					state_d = S_FINISH;
				end
			end
			S_READ: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd     = tcw_pkg::DP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd == tcw_pkg::DP_RESULT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/tcw_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer datapath
// Holds the request, the cursor and the result, and drives the screen RAM
// for puts, the scroll copy and the clearing sweep.
// ----------------------------------------------------------------------------
module tcw_datapath #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tcw_pkg::dp_cmd_t                  cmd,
	output tcw_pkg::dp_status_t                    status,
	input  wire logic [tcw_pkg::ACTION_W-1:0]      action,
	input  wire logic [tcw_pkg::CHAR_W-1:0]        char_code,
	input  wire logic [tcw_pkg::ATTR_W-1:0]        attribute,
	input  wire logic [tcw_pkg::INDEX_W-1:0]       cell_index,
	output logic      [tcw_pkg::DATA_W-1:0]        cell_data,
	output logic      [tcw_pkg::COLPORT_W-1:0]     cursor_column,
	output logic      [tcw_pkg::ROWPORT_W-1:0]     cursor_row,
	output logic                                   did_scroll
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int MOVE   = CELLS - COLUMNS;
	localparam int AW     = $clog2(CELLS);
	localparam int CNW    = $clog2(CELLS + 1);
	localparam int CW     = $clog2(COLUMNS + 1);
	localparam int RW     = $clog2(ROWS + 1);

	logic [tcw_pkg::ACTION_W-1:0] act_q;
	logic [tcw_pkg::CHAR_W-1:0]   ch_q;
	logic [tcw_pkg::ATTR_W-1:0]   attr_q;
	logic [tcw_pkg::INDEX_W-1:0]  idx_q;

	logic [CW-1:0]              col_q;
	logic [RW-1:0]              row_q;
	logic [AW-1:0]              addr_q;
	logic [tcw_pkg::TAB_W-1:0]  left_q;
	logic                       scrolled_q;
	logic                       more_q;
	logic [CNW-1:0]             cnt_q;

	logic [tcw_pkg::DATA_W-1:0]    cell_data_q;
	logic [tcw_pkg::COLPORT_W-1:0] cursor_column_q;
	logic [tcw_pkg::ROWPORT_W-1:0] cursor_row_q;
	logic                          did_scroll_q;

	logic                       at_col_end;
	logic                       at_bottom;
	logic                       put_more;
	logic                       is_newline;
	logic                       is_tab;
	logic [tcw_pkg::DATA_W-1:0] put_val;
	logic [CNW:0]               rd_sum;
	logic [AW-1:0]              scroll_raddr;
	logic                       scroll_last;
	logic                       zero_last;
	logic                       idx_in_range;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [tcw_pkg::DATA_W-1:0] ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [tcw_pkg::DATA_W-1:0] ram_rdata;

	assign is_newline = (ch_q == tcw_pkg::CH_NEWLINE);
	assign is_tab     = (ch_q == tcw_pkg::CH_TAB);
	assign at_col_end = (col_q == CW'(COLUMNS));
	assign at_bottom  = at_col_end && (row_q == RW'(ROWS));
	assign put_val    = (is_newline || is_tab) ? {tcw_pkg::PAD_ATTR, tcw_pkg::CH_SPACE}
	                                           : {attr_q, ch_q};

	always_comb begin
		if (is_newline) begin
			put_more = !at_col_end;
		end else if (is_tab) begin
			put_more = (left_q != tcw_pkg::TAB_W'(1));
		end else begin
			put_more = 1'b0;
		end
	end

	assign rd_sum       = {1'b0, cnt_q} + (CNW + 1)'(COLUMNS);
	assign scroll_raddr = (rd_sum < (CNW + 1)'(CELLS)) ? AW'(rd_sum) : '0;
	assign scroll_last  = (cnt_q == CNW'(CELLS));
	assign zero_last    = (cnt_q == CNW'(CELLS - 1));
	assign idx_in_range = (32'(idx_q) < CELLS);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = put_val;
		ram_raddr = AW'(idx_q);
		case (cmd)
			tcw_pkg::DP_PUT: begin
				ram_we = 1'b1;
			end
			tcw_pkg::DP_SCROLL: begin
				ram_raddr = scroll_raddr;
				ram_we    = (cnt_q != '0);
				ram_waddr = AW'(cnt_q - CNW'(1));
				ram_wdata = (cnt_q <= CNW'(MOVE)) ? ram_rdata : '0;
			end
			tcw_pkg::DP_ZERO: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(cnt_q);
				ram_wdata = '0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tcw_ram #(
		.WIDTH(tcw_pkg::DATA_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd == tcw_pkg::DP_LATCH) begin
			act_q  <= action;
			ch_q   <= char_code;
			attr_q <= attribute;
			idx_q  <= cell_index;
		end
		if (cmd == tcw_pkg::DP_RESULT) begin
			cell_data_q     <= (act_q == tcw_pkg::ACT_READ && idx_in_range) ? ram_rdata : '0;
			cursor_column_q <= tcw_pkg::COLPORT_W'(col_q);
			cursor_row_q    <= tcw_pkg::ROWPORT_W'(row_q);
			did_scroll_q    <= scrolled_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= CW'(1);
			row_q      <= RW'(1);
			addr_q     <= '0;
			left_q     <= '0;
			scrolled_q <= 1'b0;
			more_q     <= 1'b0;
			cnt_q      <= '0;
		end else begin
			case (cmd)
				tcw_pkg::DP_LATCH: begin
					cnt_q      <= '0;
					left_q     <= tcw_pkg::TAB_W'(tcw_pkg::TAB_SPACES);
					scrolled_q <= 1'b0;
				end
				tcw_pkg::DP_PUT: begin
					cnt_q  <= '0;
					more_q <= put_more;
					left_q <= left_q - tcw_pkg::TAB_W'(1);
					if (at_bottom) begin
						col_q      <= CW'(1);
						row_q      <= RW'(ROWS);
						addr_q     <= AW'(MOVE);
						scrolled_q <= 1'b1;
					end else if (at_col_end) begin
						col_q  <= CW'(1);
						row_q  <= row_q + RW'(1);
						addr_q <= addr_q + AW'(1);
					end else begin
						col_q  <= col_q + CW'(1);
						addr_q <= addr_q + AW'(1);
					end
				end
				tcw_pkg::DP_SCROLL: begin
					cnt_q <= cnt_q + CNW'(1);
				end
				tcw_pkg::DP_ZERO: begin
					cnt_q  <= cnt_q + CNW'(1);
					col_q  <= CW'(1);
					row_q  <= RW'(1);
					addr_q <= '0;
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	always_comb begin
		status.act         = act_q;
		status.put_bottom  = at_bottom;
		status.put_more    = put_more;
		status.more_q      = more_q;
		status.scroll_last = scroll_last;
		status.zero_last   = zero_last;
	end

	assign cell_data     = cell_data_q;
	assign cursor_column = cursor_column_q;
	assign cursor_row    = cursor_row_q;
	assign did_scroll    = did_scroll_q;

endmodule
`default_nettype wire

// ----- rtl/text_console_writer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode screen store of COLUMNS by ROWS cells with a cursor that puts
// characters, pads newlines and tabs, scrolls, clears and reads cells.
//
//   Channel  Handshake            Payload
//   in       in_valid, in_stall   action, char_code, attribute, cell_index
//   out      out_valid, out_stall cell_data, cursor_column, cursor_row, did_scroll
//
// One request is worked at a time on a single RAM write port. A newline pads
// spaces to the end of the row and a tab pads TAB_SPACES spaces; a put into the
// last cell scrolls the screen up one row and a clear zeroes every cell. After
// reset a clearing pass over all COLUMNS*ROWS cells (2000 by default) runs with
// in_stall high. A result waits in the output register under out_stall while the
// next request is taken; that one is then held until it frees.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [tcw_pkg::ACTION_W-1:0]  action,
	input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  wire logic [tcw_pkg::ATTR_W-1:0]    attribute,
	input  wire logic [tcw_pkg::INDEX_W-1:0]   cell_index,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [tcw_pkg::DATA_W-1:0]    cell_data,
	output logic      [tcw_pkg::COLPORT_W-1:0] cursor_column,
	output logic      [tcw_pkg::ROWPORT_W-1:0] cursor_row,
	output logic                               did_scroll
);

	tcw_pkg::dp_cmd_t    dp_cmd;
	tcw_pkg::dp_status_t dp_status;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	tcw_datapath #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.status       (dp_status),
		.action       (action),
		.char_code    (char_code),
		.attribute    (attribute),
		.cell_index   (cell_index),
		.cell_data    (cell_data),
		.cursor_column(cursor_column),
		.cursor_row   (cursor_row),
		.did_scroll   (did_scroll)
	);

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is being worked");

	a_idle_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (dp_cmd == tcw_pkg::DP_NONE || dp_cmd == tcw_pkg::DP_LATCH))
		else $error("datapath command issued while idle");

	a_scroll_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && did_scroll |-> cursor_row == tcw_pkg::ROWPORT_W'(ROWS))
		else $error("scroll reported with cursor off the last row");

	a_result_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd == tcw_pkg::DP_RESULT |=> out_valid)
		else $error("result loaded without valid");
`endif

endmodule
`default_nettype wire
